// ===== hdl/u2u8_pkg.sv =====
`default_nettype none

package u2u8_pkg;

   localparam int CodeUnitWidth  = 16;
   localparam int CodePointWidth = 21;
   localparam int ByteWidth      = 8;
   localparam int SurBitsWidth   = 10;

   // upper six bits of a surrogate code unit
   localparam logic [5:0] SurHighTag = 6'b110110;
   localparam logic [5:0] SurLowTag  = 6'b110111;

   localparam logic [CodePointWidth-1:0] PlaneOne = 21'h010000;
   localparam logic [CodePointWidth-1:0] Limit1B  = 21'h000080;
   localparam logic [CodePointWidth-1:0] Limit2B  = 21'h000800;
   localparam logic [CodePointWidth-1:0] Limit3B  = 21'h010000;

   // user bits of the result channel
   localparam int UserDoneBit  = 0;
   localparam int UserErrorBit = 1;
   localparam int UserWidth    = 2;

   typedef struct packed {
      logic [CodePointWidth-1:0] code_point;
      logic                      error;
      logic                      string_end;
   } u2u8_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } u2u8_queue_status_type;

endpackage

`default_nettype wire

// ===== hdl/u2u8_front.sv =====
`default_nettype none

module u2u8_front
   import u2u8_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [CodeUnitWidth-1:0]   req_tdata,
   input  wire logic                       req_tlast,
   input  wire u2u8_queue_status_type      queue_status,
   output logic                            push,
   output u2u8_job_type                    push_job
);

   logic                    high_pending_ff, high_pending_in;
   logic [SurBitsWidth-1:0] high_bits_ff, high_bits_in;
   logic                    discarding_ff, discarding_in;
   logic                    accept;
   logic                    is_high;
   logic                    is_low;
   logic [CodePointWidth-1:0] pair_cp;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_high    = req_tdata[15:10] == SurHighTag;
   assign is_low     = req_tdata[15:10] == SurLowTag;
   assign pair_cp    = {1'b0, high_bits_ff, req_tdata[SurBitsWidth-1:0]} + PlaneOne;

   always_comb begin
      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      discarding_in   = discarding_ff;
      push            = 1'b0;
      push_job.code_point = {{(CodePointWidth-CodeUnitWidth){1'b0}}, req_tdata};
      push_job.error      = 1'b0;
      push_job.string_end = req_tlast;
      if (accept) begin
         if (discarding_ff) begin
            // string already flagged, only its end reports again
            push           = req_tlast;
            push_job.error = 1'b1;
         end else if (high_pending_ff) begin
            high_pending_in = 1'b0;
            push            = 1'b1;
            if (is_low) begin
               push_job.code_point = pair_cp;
            end else begin
               push_job.error = 1'b1;
               discarding_in  = 1'b1;
            end
         end else if (is_high) begin
            if (req_tlast) begin
               push           = 1'b1;
               push_job.error = 1'b1;
            end else begin
               high_pending_in = 1'b1;
               high_bits_in    = req_tdata[SurBitsWidth-1:0];
            end
         end else if (is_low) begin
            push           = 1'b1;
            push_job.error = 1'b1;
            discarding_in  = 1'b1;
         end else begin
            push = 1'b1;
         end
         if (req_tlast) begin
            high_pending_in = 1'b0;
            high_bits_in    = '0;
            discarding_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
         discarding_ff   <= 1'b0;
      end else begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
         discarding_ff   <= discarding_in;
      end
   end

   // an error always drops the held high surrogate
   assert property (@(posedge clock) disable iff (reset)
      !(high_pending_ff && discarding_ff))
      else $error("held surrogate while discarding");

endmodule

`default_nettype wire

// ===== hdl/u2u8_queue.sv =====
`default_nettype none

module u2u8_queue
   import u2u8_pkg::*;
#(
   parameter int Depth = 4
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire u2u8_job_type          push_job,
   input  wire logic                  pop,
   output u2u8_job_type               head_job,
   output u2u8_queue_status_type      status
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   u2u8_job_type              entry_ff [Depth];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]     count_ff, count_in;

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff == FullCount;
   assign status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("queue overflow");

   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("queue underflow");

endmodule

`default_nettype wire

// ===== hdl/u2u8_back.sv =====
`default_nettype none

module u2u8_back
   import u2u8_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire u2u8_job_type          head_job,
   input  wire u2u8_queue_status_type queue_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [ByteWidth-1:0]       rsp_tdata,
   output logic                       rsp_tlast,
   output logic [UserWidth-1:0]       rsp_tuser
);

   u2u8_job_type          cur_ff;
   logic                  cur_valid_ff, cur_valid_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  rsp_tvalid_ff;
   logic [ByteWidth-1:0]  rsp_tdata_ff;
   logic                  rsp_tlast_ff;
   logic [UserWidth-1:0]  rsp_tuser_ff;

   logic                  advance;
   logic                  emit;
   logic [1:0]            last_idx;
   logic                  cur_last;
   logic [ByteWidth-1:0]  cur_byte;
   logic [CodePointWidth-1:0] cp;

   assign cp       = cur_ff.code_point;
   assign advance  = !rsp_tvalid_ff || rsp_tready;
   assign emit     = cur_valid_ff && advance;
   assign cur_last = idx_ff == last_idx;
   assign pop      = !queue_status.empty && (!cur_valid_ff || (emit && cur_last));

   always_comb begin
      if (cur_ff.error || cp < Limit1B) begin
         last_idx = 2'd0;
      end else if (cp < Limit2B) begin
         last_idx = 2'd1;
      end else if (cp < Limit3B) begin
         last_idx = 2'd2;
      end else begin
         last_idx = 2'd3;
      end
   end

   // lead byte carries the length, the rest six bits each
   always_comb begin
      cur_byte = {2'b10, cp[5:0]};
      case (last_idx)
         2'd0: begin
            cur_byte = cur_ff.error ? '0 : {1'b0, cp[6:0]};
         end
         2'd1: begin
            if (idx_ff == 2'd0) cur_byte = {3'b110, cp[10:6]};
         end
         2'd2: begin
            case (idx_ff)
               2'd0:    cur_byte = {4'b1110, cp[15:12]};
               2'd1:    cur_byte = {2'b10, cp[11:6]};
               default: cur_byte = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx_ff)
               2'd0:    cur_byte = {5'b11110, cp[20:18]};
               2'd1:    cur_byte = {2'b10, cp[17:12]};
               2'd2:    cur_byte = {2'b10, cp[11:6]};
               default: cur_byte = {2'b10, cp[5:0]};
            endcase
         end
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      cur_valid_in = cur_valid_ff;
      if (emit) begin
         idx_in = cur_last ? 2'd0 : idx_ff + 2'd1;
         if (cur_last) cur_valid_in = 1'b0;
      end
      if (pop) cur_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         if (advance) rsp_tvalid_ff <= cur_valid_ff;
      end
      if (pop) cur_ff <= head_job;
      if (emit) begin
         rsp_tdata_ff               <= cur_byte;
         rsp_tlast_ff               <= cur_last;
         rsp_tuser_ff[UserDoneBit]  <= cur_last && cur_ff.string_end;
         rsp_tuser_ff[UserErrorBit] <= cur_ff.error;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // an error is a single zero byte that closes its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[UserErrorBit]) |-> (rsp_tlast && rsp_tdata == '0))
      else $error("malformed error result");

endmodule

`default_nettype wire

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder.
// req_ channel: one UTF-16 code unit per request, tlast on the final unit of
// a string. rsp_ channel: one UTF-8 byte per result, most significant first,
// tlast on the last byte caused by a unit, tuser flags end of string and error.
// A front stage tracks surrogate pairs and error state and queues one job per
// unit that yields output; a back stage serializes each job into bytes.
// The first byte of a unit passes the queue, the back stage's job register and
// the output register. The output register gives one byte per cycle while
// rsp_tready is high, so a unit gives one to three bytes (a surrogate pair four,
// over its two units); a held high surrogate and a discarded unit give no output.
// An error gives a single zero byte with the error flag; later units of that
// string give nothing until its final unit, which gives one more error byte.
// Reset clears the surrogate and error state and empties the job queue.
// When rsp_tready is low the output register holds; the queue of QueueDepth
// jobs keeps accepting until full, then req_tready drops.
`default_nettype none

module utf16_to_utf8_transcoder
   import u2u8_pkg::*;
#(
   parameter int QueueDepth = 4
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [CodeUnitWidth-1:0]  req_tdata,   // [15:0] code_unit
   input  wire logic                      req_tlast,   // string_end
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [ByteWidth-1:0]           rsp_tdata,   // [7:0] utf8_byte
   output logic                           rsp_tlast,   // run_last
   output logic [UserWidth-1:0]           rsp_tuser    // [0] string_done, [1] error
);

   u2u8_queue_status_type queue_status;
   u2u8_job_type          push_job;
   u2u8_job_type          head_job;
   logic                  push;
   logic                  pop;

   u2u8_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   u2u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   u2u8_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

`default_nettype wire
